@@ hw/rtl/cfa_pkg.sv @@
// ============================================================================
// cfa_pkg: shared types and constants for the contiguous frame allocator
// Holds the default sizes, the status codes and the control state encoding.
// ============================================================================
package cfa_pkg;

    localparam int NUM_FRAMES_DEF = 256;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int KB_PER_FRAME   = 4;
    localparam int KB_W           = 16;
    // frames needed by the largest request: ceil(65535 / 4) = 16384
    localparam int NEED_W         = 15;
    localparam int FC_W           = 9;
    localparam int FC_MAX         = 511;
    localparam int CTR_W          = 16;

    typedef enum logic [1:0] {
        ST_ALLOCATED     = 2'd0,
        ST_INSUFFICIENT  = 2'd1,
        ST_FRAGMENTED    = 2'd2,
        ST_FREED         = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_SPARE = 2'd3
    } t_fit;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_FREE  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/contiguous_frame_allocator.sv @@
// ============================================================================
// contiguous_frame_allocator: first/best/worst fit contiguous frame allocator
// Owner table as a rotating ring of cells, scanned by a small controller.
// ============================================================================
// The frame owner table lives in a ring of NUM_FRAMES cells that rotates by
// one frame a cycle during a pass, so the controller sees the frames at the
// ring head in index order. A begin request that needs a search takes one
// scan pass and, when a hole is found, one write pass; a zero-size or
// insufficient request goes straight to its result. An end request takes one
// free pass over the ring. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// fit_strategy is written through the cfg channel.
module contiguous_frame_allocator
    import cfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: fit_strategy
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    // request: tdata = owner_id[15:0], request_kb[31:16]; tuser = opcode[0]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    // result: tdata = frame_count[8:0], start_frame[16:9], free_frames[25:17],
    //   insufficient_total[41:26], fragmentation_total[57:42], zero[63:58]
    // tuser = status[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    output logic [1:0]  o_m_tuser
);

    localparam int FIDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_FRAMES);

    t_state              r_state;
    logic [1:0]          r_fit;
    logic [ID_WIDTH-1:0] r_id;
    logic [NEED_W-1:0]   r_need;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_free;
    logic [CNT_W-1:0]    r_freed;
    logic [FIDX_W-1:0]   r_run_start;
    logic [CNT_W-1:0]    r_run_len;
    logic                r_found;
    logic [FIDX_W-1:0]   r_pick;
    logic [CNT_W-1:0]    r_pick_len;
    logic [CTR_W-1:0]    r_insuf;
    logic [CTR_W-1:0]    r_frag;
    t_status             r_status;
    logic [FC_W-1:0]     r_count;
    logic [7:0]          r_start;
    logic                r_out_valid;
    logic [63:0]         r_out_data;
    logic [1:0]          r_out_user;

    logic [ID_WIDTH-1:0] w_owner [NUM_FRAMES];
    logic [ID_WIDTH-1:0] w_tail;
    logic                w_shift;
    logic [ID_WIDTH-1:0] w_head;
    logic                w_accept;
    logic [ID_WIDTH-1:0] w_in_id;
    logic [NEED_W-1:0]   w_in_need;
    logic                w_at_end;
    logic                w_is_free;
    logic                w_run_fits;
    logic                w_take;
    logic                w_in_run;
    logic                w_match;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_freed_sum;

    assign w_head     = w_owner[0];
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_id    = ID_WIDTH'(i_s_tdata[15:0]);
    assign w_in_need  = NEED_W'(({1'b0, i_s_tdata[31:16]} + 17'(KB_PER_FRAME - 1)) >> 2);
    assign w_at_end   = (r_idx == LAST_IDX);
    assign w_is_free  = !w_at_end && (w_head == '0);
    assign w_run_fits = (r_run_len != '0) && ({1'b0, r_run_len} >= (NEED_W + 1)'(r_need));
    assign w_in_run   = (r_idx >= CNT_W'(r_pick))
                     && ({1'b0, r_idx} < ((CNT_W + 1)'(r_pick) + (CNT_W + 1)'(r_need)));
    assign w_match    = (r_id != '0) && (w_head == r_id);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_freed_sum = r_freed + CNT_W'(w_match);

    // pick rule for a fitting hole
    always_comb begin
        case (r_fit)
            FIT_FIRST: w_take = !r_found;
            FIT_BEST:  w_take = !r_found || (r_run_len < r_pick_len);
            default:   w_take = !r_found || (r_run_len >= r_pick_len);
        endcase
    end

    // rotate the ring during a pass, feeding the updated head to the tail
    always_comb begin
        w_shift = 1'b0;
        w_tail  = w_head;
        unique case (r_state)
            S_SCAN:  w_shift = !w_at_end;
            S_WRITE: begin
                w_shift = 1'b1;
                if (w_in_run) begin
                    w_tail = r_id;
                end
            end
            S_FREE:  begin
                w_shift = 1'b1;
                if (w_match) begin
                    w_tail = '0;
                end
            end
            default: w_shift = 1'b0;
        endcase
    end

    // owner ring
    for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
        logic [ID_WIDTH-1:0] w_next;
        if (k == NUM_FRAMES - 1) begin : g_tail
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_owner[k+1];
        end
        cfa_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_owner (w_next),
            .o_owner (w_owner[k])
        );
    end

    // take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= FIT_FIRST;
        end else if (i_cfg_valid) begin
            r_fit <= i_cfg_data;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= LAST_IDX;
            r_insuf  <= '0;
            r_frag   <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_id        <= w_in_id;
                        r_need      <= w_in_need;
                        r_idx       <= '0;
                        r_freed     <= '0;
                        r_run_len   <= '0;
                        r_run_start <= '0;
                        r_found     <= 1'b0;
                        r_pick      <= '0;
                        r_pick_len  <= '0;
                        r_start     <= '0;
                        r_count     <= (w_in_need > NEED_W'(FC_MAX)) ? FC_W'(FC_MAX)
                                                                     : FC_W'(w_in_need);
                        if (i_s_tuser[0]) begin
                            r_status <= ST_FREED;
                            r_state  <= S_FREE;
                        end else if (w_in_need == '0) begin
                            r_status <= ST_ALLOCATED;
                            r_state  <= S_DONE;
                        end else if ((NEED_W + 1)'(r_free) < (NEED_W + 1)'(w_in_need)) begin
                            r_status <= ST_INSUFFICIENT;
                            if (r_insuf != '1) begin
                                r_insuf <= r_insuf + 1'b1;
                            end
                            r_state  <= S_DONE;
                        end else begin
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // extend the current hole or close it and weigh it
                    if (w_is_free) begin
                        if (r_run_len == '0) begin
                            r_run_start <= FIDX_W'(r_idx);
                        end
                        r_run_len <= r_run_len + 1'b1;
                    end else begin
                        if (w_run_fits && w_take) begin
                            r_found    <= 1'b1;
                            r_pick     <= r_run_start;
                            r_pick_len <= r_run_len;
                        end
                        r_run_len <= '0;
                    end
                    if (w_at_end) begin
                        r_idx <= '0;
                        if (r_found || (w_run_fits && w_take)) begin
                            r_status <= ST_ALLOCATED;
                            r_start  <= (w_run_fits && w_take) ? 8'(r_run_start)
                                                               : 8'(r_pick);
                            r_state  <= S_WRITE;
                        end else begin
                            r_status <= ST_FRAGMENTED;
                            if (r_frag != '1) begin
                                r_frag <= r_frag + 1'b1;
                            end
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (r_idx == LAST_IDX - 1'b1) begin
                        if (r_id != '0) begin
                            r_free <= r_free - CNT_W'(r_need);
                        end
                        r_state <= S_DONE;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_FREE: begin
                    r_freed <= w_freed_sum;
                    if (r_idx == LAST_IDX - 1'b1) begin
                        r_free  <= r_free + w_freed_sum;
                        r_count <= ((CNT_W + 1)'(w_freed_sum) > (CNT_W + 1)'(FC_MAX))
                                   ? FC_W'(FC_MAX) : FC_W'(w_freed_sum);
                        r_state <= S_DONE;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load when the result is done and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_user <= r_status;
            r_out_data <= {6'd0, r_frag, r_insuf, 9'(r_free), r_start, r_count};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

@@ hw/rtl/cfa_cell.sv @@
// ============================================================================
// cfa_cell: one frame owner cell of the rotating owner ring
// Holds the owner id of one frame and takes its neighbor's value on a shift.
// ============================================================================
module cfa_cell #(
    parameter int ID_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [ID_WIDTH-1:0] i_owner,
    output logic [ID_WIDTH-1:0] o_owner
);

    logic [ID_WIDTH-1:0] r_owner;

    // clear to free on reset, take the neighbor's owner on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
        end else if (i_shift) begin
            r_owner <= i_owner;
        end
    end

    assign o_owner = r_owner;

endmodule
